// ----- rtl/core/bfpa_pkg.sv -----
// Shared types and constants for the best-fit partition allocator.
// No dependencies; bfpa_ifs.sv and the top level import this package.
`default_nettype none
package bfpa_pkg;

   localparam int SIZE_W             = 16;
   localparam int NUM_W              = 5;
   localparam int STATUS_W           = 2;
   localparam int DEF_NUM_PARTITIONS = 32;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_LOADED    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/bfpa_ifs.sv -----
// Valid/ready channel interfaces for the request and response beats.
// Depends on bfpa_pkg for field widths.
`default_nettype none
interface bfpa_req_if;
   import bfpa_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [SIZE_W-1:0] item_size;

   modport source (output valid, output mode, output item_size, input ready);
   modport sink   (input valid, input mode, input item_size, output ready);
endinterface

interface bfpa_rsp_if;
   import bfpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NUM_W-1:0]    partition_number;
   logic [SIZE_W-1:0]   leftover_space;

   modport source (output valid, output status, output partition_number,
                   output leftover_space, input ready);
   modport sink   (input valid, input status, input partition_number,
                   input leftover_space, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bfpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none
module bfpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/best_fit_partition_allocator.sv -----
// Best-fit partition allocator: top level with sequencer and compare unit.
// Depends on bfpa_pkg, bfpa_req_if/bfpa_rsp_if and bfpa_ram.
`default_nettype none
// A load beat (mode 0) appends one partition size to the table and answers
// with the new partition number, or with table full once NUM_PARTITIONS are
// loaded. A request beat (mode 1) grants the smallest free partition that is
// at least the requested size, lowest number on a tie, and reports the
// leftover space, or reports no fit. The size table sits in a RAM with one
// registered read port and a single comparator walks the loaded entries one
// entry per cycle, then drains the last read before the finish step. The
// result is held in an output register, so a new beat may be accepted while
// the previous result waits. Used flags are cleared by reset at once.
module best_fit_partition_allocator #(
   parameter int NUM_PARTITIONS = bfpa_pkg::DEF_NUM_PARTITIONS
) (
   input wire logic clock,
   input wire logic reset,
   bfpa_req_if.sink   req_ch,
   bfpa_rsp_if.source rsp_ch
);
   import bfpa_pkg::*;

   localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_PARTITIONS);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [NUM_PARTITIONS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]          addr_ff, addr_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                      mode_ff, mode_in;
   logic [SIZE_W-1:0]         req_size_ff, req_size_in;
   logic                      found_ff, found_in;
   logic [IDX_W-1:0]          best_ff, best_in;
   logic [SIZE_W-1:0]         best_size_ff, best_size_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]          rsp_num_ff, rsp_num_in;
   logic [SIZE_W-1:0]         rsp_left_ff, rsp_left_in;

   logic                      wr_en;
   logic [SIZE_W-1:0]         rd_data;
   logic                      accept;
   logic                      out_free;
   logic                      fits;

   bfpa_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (NUM_PARTITIONS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_ch.item_size),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign accept                  = req_ch.valid && req_ch.ready;
   assign wr_en                   = accept && (req_ch.mode == MODE_LOAD) && (count_ff < N_CNT);
   assign out_free                = !rsp_valid_ff || rsp_ch.ready;
   assign fits                    = !used_ff[cmp_idx_ff] && (rd_data >= req_size_ff);

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.partition_number = rsp_num_ff;
   assign rsp_ch.leftover_space   = rsp_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      mode_ff       <= mode_in;
      req_size_ff   <= req_size_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_size_ff  <= best_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_left_ff   <= rsp_left_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      addr_in       = addr_ff;
      rd_pend_in    = 1'b0;
      cmp_idx_in    = addr_ff[IDX_W-1:0];
      mode_in       = mode_ff;
      req_size_in   = req_size_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_size_in  = best_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_left_in   = rsp_left_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in     = req_ch.mode;
               req_size_in = req_ch.item_size;
               addr_in     = '0;
               if (req_ch.mode == MODE_LOAD) begin
                  // For a load, found marks that a slot was free.
                  found_in = (count_ff < N_CNT);
                  best_in  = count_ff[IDX_W-1:0];
                  if (count_ff < N_CNT) begin
                     used_in[count_ff[IDX_W-1:0]] = 1'b0;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_FINISH;
               end else begin
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one read per cycle; the compare runs on the read data in the cycle after each read.
            if (addr_ff < count_ff) begin
               rd_pend_in = 1'b1;
               addr_in    = addr_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = S_FINISH;
            end
            if (rd_pend_ff && fits && (!found_ff || rd_data < best_size_ff)) begin
               found_in     = 1'b1;
               best_in      = cmp_idx_ff;
               best_size_in = rd_data;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = '0;
               rsp_left_in  = '0;
               if (mode_ff == MODE_LOAD) begin
                  rsp_status_in = found_ff ? ST_LOADED : ST_FULL;
                  if (found_ff) begin
                     rsp_num_in = NUM_W'(best_ff);
                  end
               end else if (found_ff) begin
                  rsp_status_in    = ST_ALLOCATED;
                  rsp_num_in       = NUM_W'(best_ff);
                  rsp_left_in      = best_size_ff - req_size_ff;
                  used_in[best_ff] = 1'b1;
               end else begin
                  rsp_status_in = ST_NO_FIT;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The table never holds more partitions than it has room for.
   assert property (@(posedge clock) disable iff (reset) count_ff <= N_CNT)
      else $error("partition count exceeds table depth");

   // Only loaded partitions can carry a used flag.
   assert property (@(posedge clock) disable iff (reset)
      (used_ff >> count_ff) == '0)
      else $error("used flag set beyond loaded partitions");

   // The scan address never runs past the loaded entries.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> addr_ff <= count_ff)
      else $error("scan address past partition count");

   // A new response only appears after the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside finish step");

   // Leftover space is reported only for a granted partition.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_ALLOCATED |-> rsp_left_ff == '0)
      else $error("nonzero leftover space without allocation");

endmodule
`default_nettype wire
